### rtl/enfs_pkg.sv
// Shared constants and transaction types for the next-floor selector.
package enfs_pkg;

   localparam int FLOORS  = 4;
   localparam int FLOOR_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;
   localparam int HALL_W  = FLOORS - 1;

   typedef struct packed {
      logic [FLOOR_W-1:0] car_floor;
      logic               last_dir_down;
      logic [FLOORS-1:0]  cab_request_mask;
      logic [HALL_W-1:0]  hall_up_mask;
      logic [HALL_W-1:0]  hall_down_mask;
   } req_type;

   typedef struct packed {
      logic               goal_valid;
      logic [FLOOR_W-1:0] goal_floor;
   } rsp_type;

endpackage

### rtl/enfs_goal_pick.sv
// Combinational goal floor decision for one registered request.
module enfs_goal_pick
   import enfs_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   // {hit, index} of the lowest set bit strictly above the car
   function automatic logic [FLOOR_W:0] low_above(input logic [FLOORS-1:0] m,
                                                  input logic [FLOOR_W-1:0] fl);
      logic [FLOOR_W:0] r;
      r = '0;
      for (int f = FLOORS - 1; f >= 0; f--) begin
         if (m[f] && (FLOOR_W'(f) > fl)) begin
            r = {1'b1, FLOOR_W'(f)};
         end
      end
      return r;
   endfunction

   // {hit, index} of the highest set bit strictly below the car
   function automatic logic [FLOOR_W:0] high_below(input logic [FLOORS-1:0] m,
                                                   input logic [FLOOR_W-1:0] fl);
      logic [FLOOR_W:0] r;
      r = '0;
      for (int f = 0; f < FLOORS; f++) begin
         if (m[f] && (FLOOR_W'(f) < fl)) begin
            r = {1'b1, FLOOR_W'(f)};
         end
      end
      return r;
   endfunction

   logic [FLOOR_W-1:0] floor_sel;
   logic [FLOORS-1:0]  cab;
   logic [FLOORS-1:0]  up;
   logic [FLOORS-1:0]  dn;
   logic [FLOORS-1:0]  any_call;
   logic [FLOORS-1:0]  ahead_up;
   logic [FLOORS-1:0]  ahead_dn;
   logic [FLOOR_W:0]   cab_up_hit;
   logic [FLOOR_W:0]   cab_dn_hit;
   logic               cab_above;
   logic               cab_below;
   logic               go_up;
   logic [FLOOR_W:0]   first_hit;
   logic [FLOOR_W:0]   second_hit;

   always_comb begin
      floor_sel = req.car_floor;
      if (req.car_floor > FLOOR_W'(FLOORS - 1)) begin
         floor_sel = FLOOR_W'(FLOORS - 1);
      end

      // hall up has no top floor, hall down has no bottom floor
      cab      = req.cab_request_mask;
      up       = {1'b0, req.hall_up_mask};
      dn       = {req.hall_down_mask, 1'b0};
      any_call = cab | up | dn;

      cab_up_hit = low_above(cab, floor_sel);
      cab_dn_hit = high_below(cab, floor_sel);
      cab_above  = cab_up_hit[FLOOR_W];
      cab_below  = cab_dn_hit[FLOOR_W];

      if (cab_above && !cab_below) begin
         go_up = 1'b1;
      end else if (cab_below && !cab_above) begin
         go_up = 1'b0;
      end else begin
         go_up = !req.last_dir_down;
      end

      // stops allowed on the outbound sweep
      if (cab_above || cab_below) begin
         ahead_up = cab | up;
         ahead_dn = cab | dn;
      end else begin
         ahead_up = up | dn;
         ahead_dn = up | dn;
      end

      if (go_up) begin
         first_hit  = low_above(ahead_up, floor_sel);
         second_hit = high_below(any_call, floor_sel);
      end else begin
         first_hit  = high_below(ahead_dn, floor_sel);
         second_hit = low_above(any_call, floor_sel);
      end

      if (any_call[floor_sel]) begin
         rsp = '{goal_valid: 1'b1, goal_floor: floor_sel};
      end else if (first_hit[FLOOR_W]) begin
         rsp = '{goal_valid: 1'b1, goal_floor: first_hit[FLOOR_W-1:0]};
      end else if (second_hit[FLOOR_W]) begin
         rsp = '{goal_valid: 1'b1, goal_floor: second_hit[FLOOR_W-1:0]};
      end else begin
         rsp = '{goal_valid: 1'b0, goal_floor: '0};
      end
   end

endmodule

### rtl/elevator_next_floor_select.sv
// Top level of the elevator next-floor selector (SCAN with cab priority).
//
//  channel  | ports                           | direction | payload
//  ---------+---------------------------------+-----------+----------
//  request  | req_valid, req_ready, req_data  | in        | req_type
//  response | rsp_valid, rsp_ready, rsp_data  | out       | rsp_type
//
// Every request transaction yields exactly one response transaction.
// Each request passes the request register, then the goal decision into the
// response register. One transaction per cycle is sustained while rsp_ready stays high; the request
// register and the response register each hold one transaction, so one new
// request is taken while a finished response waits. With both full and
// rsp_ready low, req_ready stays low until the response is taken.
// Reset (synchronous, active high) empties both stages; there is no other state.
module elevator_next_floor_select
   import enfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // request stage
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_data_ff;

   // response stage
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   rsp_type goal;
   logic    s1_move;
   logic    req_take;

   enfs_goal_pick u_goal_pick (
      .req (s1_data_ff),
      .rsp (goal)
   );

   // request stage drains whenever the response slot is free or being emptied
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= goal;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no target always reports floor zero
   a_no_goal_floor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.goal_valid |-> rsp_data.goal_floor == '0)
      else $error("response without goal carries a non-zero floor");

   // a held request reaches an empty response slot on the next edge
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("request stage failed to advance into empty response slot");

   // empty request stage never back-pressures
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("request not ready although request stage is empty");

endmodule

### bench/elevator_next_floor_select_tb.sv
// Self-checking bench for the elevator next-floor selector: directed and random call snapshots.
`timescale 1ns / 100ps

module elevator_next_floor_select_tb
   import enfs_pkg::*;
();

   // Run length limits, in clock cycles
   localparam int RUN_LIMIT    = 200000;  // generous: ~1400 transactions at heavy stall
   localparam int DRAIN_CYCLES = 8;       // idle margin after the last goal returns, for strays
   localparam int RESET_CYCLES = 7;
   localparam int ITEMS_PER_PHASE = 450;  // per phase; three phases of random traffic

   // Works out the next target floor for one call snapshot and keeps the goals that
   // are still owed by the block, oldest first.
   class goal_scoreboard;
      rsp_type expected_goals[$];
      int      errors = 0;

      task report_mismatch(string what);
         $display("%0t ns: mismatch: %s", $realtime, what);
         errors++;
      endtask

      function bit cab_pending(logic [FLOORS-1:0] m, int f);
         return f >= 0 && f < FLOORS && m[f];
      endfunction

      function bit hall_up_pending(logic [HALL_W-1:0] m, int f);
         return f >= 0 && f < FLOORS - 1 && m[f];
      endfunction

      // hall down bits are offset by one: bit f-1 belongs to floor f
      function bit hall_down_pending(logic [HALL_W-1:0] m, int f);
         return f >= 1 && f < FLOORS && m[f-1];
      endfunction

      // nearest floor from 'start' walking by 'step' with a call of an accepted kind
      function int first_call(req_type r, int start, int step,
                              bit stop_cab, bit stop_up, bit stop_down);
         for (int f = start; f >= 0 && f < FLOORS; f += step)
            if ((stop_cab && cab_pending(r.cab_request_mask, f)) ||
                (stop_up && hall_up_pending(r.hall_up_mask, f)) ||
                (stop_down && hall_down_pending(r.hall_down_mask, f)))
               return f;
         return -1;
      endfunction

      function rsp_type predict_goal(req_type r);
         int      here;
         int      goal;
         bit      above;
         bit      below;
         bit      go_up;
         bit      have_cab;
         rsp_type res;
         here = int'(r.car_floor);
         if (here > FLOORS - 1)
            here = FLOORS - 1;
         above = 1'b0;
         below = 1'b0;
         for (int f = 0; f < FLOORS; f++) begin
            if (cab_pending(r.cab_request_mask, f)) begin
               if (f > here) above = 1'b1;
               if (f < here) below = 1'b1;
            end
         end
         // cab calls on one side only force the direction, else last direction decides
         if (above && !below)
            go_up = 1'b1;
         else if (below && !above)
            go_up = 1'b0;
         else
            go_up = !r.last_dir_down;
         have_cab = above || below;
         if (cab_pending(r.cab_request_mask, here) || hall_up_pending(r.hall_up_mask, here) ||
             hall_down_pending(r.hall_down_mask, here)) begin
            goal = here;
         end else begin
            // ahead: with cab calls only same-direction hall calls stop the car,
            // in plain SCAN any hall call does; behind: anything goes
            goal = first_call(r, go_up ? here + 1 : here - 1, go_up ? 1 : -1,
                              have_cab, !have_cab || go_up, !have_cab || !go_up);
            if (goal < 0)
               goal = first_call(r, go_up ? here - 1 : here + 1, go_up ? -1 : 1,
                                 have_cab, 1'b1, 1'b1);
         end
         res.goal_valid = (goal >= 0);
         res.goal_floor = (goal >= 0) ? goal[FLOOR_W-1:0] : '0;
         return res;
      endfunction

      function void note_request(req_type r);
         expected_goals.push_back(predict_goal(r));
      endfunction

      task check_goal(rsp_type got);
         rsp_type want;
         if (expected_goals.size() == 0) begin
            report_mismatch($sformatf("response valid=%0d floor=%0d with none outstanding",
                                      got.goal_valid, got.goal_floor));
            return;
         end
         want = expected_goals.pop_front();
         if (got.goal_valid !== want.goal_valid)
            report_mismatch($sformatf("goal_valid got %0d want %0d",
                                      got.goal_valid, want.goal_valid));
         if (got.goal_floor !== want.goal_floor)
            report_mismatch($sformatf("goal_floor got %0d want %0d",
                                      got.goal_floor, want.goal_floor));
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // Block connections; every input is known from time zero
   // ---------------------------------------------------------------------------
   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   goal_scoreboard board = new();

   // idle rates in percent, changed between traffic phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;

   elevator_next_floor_select i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("elevator_next_floor_select_tb: FAIL");
      $finish;
   end

   // Response side: checks each accepted transaction, then picks next cycle's ready.
   // Exactly one nonblocking write to rsp_ready per edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_goal(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request transaction. Valid is only lowered when an idle gap is
   // taken, so back-to-back transactions keep it high without a glitch in one step.
   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      // values seen here are the ones from just before the edge
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
   endtask

   task automatic send_calls(input int floor, input bit last_down, input int cab,
                             input int hall_up, input int hall_down);
      req_type item;
      item.car_floor        = floor[FLOOR_W-1:0];
      item.last_dir_down    = last_down;
      item.cab_request_mask = cab[FLOORS-1:0];
      item.hall_up_mask     = hall_up[HALL_W-1:0];
      item.hall_down_mask   = hall_down[HALL_W-1:0];
      send_item(item);
   endtask

   // Random snapshot. Dense masks nearly always hit the current floor, so most
   // snapshots are sparse to exercise the direction search and the reversal.
   task automatic send_random_calls();
      int cab;
      int hall_up;
      int hall_down;
      case ($urandom_range(3))
         0: begin
            cab       = $urandom_range(15);
            hall_up   = $urandom_range(7);
            hall_down = $urandom_range(7);
         end
         1: begin
            cab       = $urandom & $urandom & 15;
            hall_up   = $urandom & $urandom & 7;
            hall_down = $urandom & $urandom & 7;
         end
         2: begin
            cab       = $urandom & $urandom & 15;
            hall_up   = 0;
            hall_down = 0;
         end
         default: begin
            cab       = 0;
            hall_up   = $urandom & $urandom & 7;
            hall_down = $urandom & $urandom & 7;
         end
      endcase
      send_calls($urandom_range(FLOORS - 1), $urandom_range(1), cab, hall_up, hall_down);
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // phase one: light sender idling, heavy back-pressure
      send_idle_pct = 18;
      recv_idle_pct = 77;

      // directed snapshots: floor, last down, cab, hall up, hall down
      send_calls(0, 0, 4'b0000, 3'b000, 3'b000);  // nothing pending anywhere
      send_calls(3, 1, 4'b0000, 3'b000, 3'b000);
      send_calls(2, 0, 4'b0100, 3'b000, 3'b000);  // cab call at the car's floor
      send_calls(1, 0, 4'b0000, 3'b010, 3'b000);  // hall up at the car's floor
      send_calls(3, 0, 4'b0000, 3'b000, 3'b100);  // hall down at the top floor
      send_calls(0, 1, 4'b0000, 3'b000, 3'b001);  // plain SCAN, reverse from bottom
      send_calls(1, 0, 4'b1001, 3'b000, 3'b000);  // cab both sides, last up
      send_calls(1, 1, 4'b1001, 3'b000, 3'b000);  // cab both sides, last down
      send_calls(0, 1, 4'b1000, 3'b010, 3'b000);  // up trip stops for hall up en route
      send_calls(3, 0, 4'b0001, 3'b000, 3'b010);  // down trip stops for hall down en route
      send_calls(3, 0, 4'b0001, 3'b100, 3'b000);  // down trip passes a hall up call
      send_calls(0, 0, 4'b1000, 3'b000, 3'b001);  // up trip passes a hall down call
      send_calls(2, 0, 4'b0000, 3'b001, 3'b100);  // SCAN upward first
      send_calls(2, 1, 4'b0000, 3'b001, 3'b100);  // SCAN downward first
      send_calls(1, 0, 4'b0000, 3'b001, 3'b000);  // SCAN reverses to find the call
      send_calls(0, 0, 4'b1111, 3'b111, 3'b111);  // everything set
      send_calls(3, 1, 4'b0111, 3'b111, 3'b111);
      send_calls(2, 0, 4'b0010, 3'b000, 3'b000);  // cab below only
      send_calls(2, 1, 4'b1000, 3'b000, 3'b000);  // cab above only overrides last down
      send_calls(0, 0, 4'b0000, 3'b100, 3'b000);  // highest hall up call
      send_calls(3, 1, 4'b0000, 3'b001, 3'b000);  // lowest hall up call from the top
      send_calls(1, 1, 4'b0001, 3'b000, 3'b100);  // cab below wins over hall down above

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            // phase two: the roles swap
            send_idle_pct = 77;
            recv_idle_pct = 18;
         end else if (phase == 2) begin
            // phase three: full rate both ways
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (ITEMS_PER_PHASE) send_random_calls();
      end
      req_valid <= 1'b0;

      // let the outstanding goals come back, then a few idle cycles for strays
      while (board.expected_goals.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.expected_goals.size() != 0)
         board.report_mismatch($sformatf("%0d goals never returned",
                                         board.expected_goals.size()));
      if (board.errors == 0)
         $display("elevator_next_floor_select_tb: PASS");
      else
         $display("elevator_next_floor_select_tb: FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/enfs_pkg.sv
rtl/enfs_goal_pick.sv
rtl/elevator_next_floor_select.sv
bench/elevator_next_floor_select_tb.sv
